[rtl/core/ps2kq_pkg.sv]
package ps2kq_pkg;

  // Event ring geometry
  localparam int unsigned RING_DEPTH = 64;
  localparam int unsigned RING_PTR_W = $clog2(RING_DEPTH);

  // Command queue between front and back
  localparam int unsigned CMDQ_DEPTH = 2;
  localparam int unsigned CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int unsigned CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  // Result queue at the output side
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // Action codes
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // Set-1 scancodes with special handling
  localparam logic [6:0] SC_LSHIFT    = 7'h2A;
  localparam logic [6:0] SC_RSHIFT    = 7'h36;
  localparam logic [6:0] SC_LCTRL     = 7'h1D;
  localparam logic [6:0] SC_LALT      = 7'h38;
  localparam logic [6:0] SC_CAPS      = 7'h3A;
  localparam logic [6:0] SC_ENTER     = 7'h1C;
  localparam logic [6:0] SC_BACKSPACE = 7'h0E;
  localparam logic [6:0] SC_TAB       = 7'h0F;
  localparam logic [6:0] SC_SPACE     = 7'h39;

  // Forced characters
  localparam logic [6:0] CH_NEWLINE   = 7'h0A;
  localparam logic [6:0] CH_BACKSPACE = 7'h08;
  localparam logic [6:0] CH_TAB       = 7'h09;
  localparam logic [6:0] CH_SPACE     = 7'h20;

  typedef struct packed {
    logic       action;
    logic [7:0] scan_byte;
  } in_t;

  typedef struct packed {
    logic       queue_empty;
    logic [6:0] key_code;
    logic [6:0] char_code;
    logic       is_press;
    logic       shift_down;
    logic       ctrl_down;
    logic       alt_down;
  } out_t;

  // One ring entry
  typedef struct packed {
    logic [6:0] key_code;
    logic [6:0] char_code;
    logic       is_press;
    logic       shift_down;
    logic       ctrl_down;
    logic       alt_down;
  } event_t;

  localparam int unsigned EVENT_W = $bits(event_t);

  // Front-to-back command
  typedef struct packed {
    logic   is_read;
    event_t evt;
  } cmd_t;

  // Command queue head as seen by the back part
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

  typedef struct packed {
    logic shift;
    logic ctrl;
    logic alt;
    logic caps;
  } mods_t;

  function automatic logic [RING_PTR_W-1:0] ring_next(input logic [RING_PTR_W-1:0] p);
    logic [RING_PTR_W-1:0] r;
    if (p == RING_PTR_W'(RING_DEPTH - 1)) r = '0;
    else r = p + 1'b1;
    return r;
  endfunction

  // US layout, unshifted
  function automatic logic [7:0] plain_char(input logic [6:0] key);
    logic [7:0] c;
    case (key)
      7'd2:  c = "1";
      7'd3:  c = "2";
      7'd4:  c = "3";
      7'd5:  c = "4";
      7'd6:  c = "5";
      7'd7:  c = "6";
      7'd8:  c = "7";
      7'd9:  c = "8";
      7'd10: c = "9";
      7'd11: c = "0";
      7'd12: c = "-";
      7'd13: c = "=";
      7'd16: c = "q";
      7'd17: c = "w";
      7'd18: c = "e";
      7'd19: c = "r";
      7'd20: c = "t";
      7'd21: c = "y";
      7'd22: c = "u";
      7'd23: c = "i";
      7'd24: c = "o";
      7'd25: c = "p";
      7'd26: c = 8'h5B;
      7'd27: c = 8'h5D;
      7'd30: c = "a";
      7'd31: c = "s";
      7'd32: c = "d";
      7'd33: c = "f";
      7'd34: c = "g";
      7'd35: c = "h";
      7'd36: c = "j";
      7'd37: c = "k";
      7'd38: c = "l";
      7'd39: c = 8'h3B;
      7'd40: c = 8'h27;
      7'd41: c = 8'h60;
      7'd43: c = 8'h5C;
      7'd44: c = "z";
      7'd45: c = "x";
      7'd46: c = "c";
      7'd47: c = "v";
      7'd48: c = "b";
      7'd49: c = "n";
      7'd50: c = "m";
      7'd51: c = 8'h2C;
      7'd52: c = 8'h2E;
      7'd53: c = 8'h2F;
      7'd55: c = 8'h2A;
      7'd57: c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // US layout, shifted
  function automatic logic [7:0] shifted_char(input logic [6:0] key);
    logic [7:0] c;
    case (key)
      7'd2:  c = 8'h21;
      7'd3:  c = 8'h40;
      7'd4:  c = 8'h23;
      7'd5:  c = 8'h24;
      7'd6:  c = 8'h25;
      7'd7:  c = 8'h5E;
      7'd8:  c = 8'h26;
      7'd9:  c = 8'h2A;
      7'd10: c = 8'h28;
      7'd11: c = 8'h29;
      7'd12: c = 8'h5F;
      7'd13: c = 8'h2B;
      7'd16: c = "Q";
      7'd17: c = "W";
      7'd18: c = "E";
      7'd19: c = "R";
      7'd20: c = "T";
      7'd21: c = "Y";
      7'd22: c = "U";
      7'd23: c = "I";
      7'd24: c = "O";
      7'd25: c = "P";
      7'd26: c = 8'h7B;
      7'd27: c = 8'h7D;
      7'd30: c = "A";
      7'd31: c = "S";
      7'd32: c = "D";
      7'd33: c = "F";
      7'd34: c = "G";
      7'd35: c = "H";
      7'd36: c = "J";
      7'd37: c = "K";
      7'd38: c = "L";
      7'd39: c = 8'h3A;
      7'd40: c = 8'h22;
      7'd41: c = 8'h7E;
      7'd43: c = 8'h7C;
      7'd44: c = "Z";
      7'd45: c = "X";
      7'd46: c = "C";
      7'd47: c = "V";
      7'd48: c = "B";
      7'd49: c = "N";
      7'd50: c = "M";
      7'd51: c = 8'h3C;
      7'd52: c = 8'h3E;
      7'd53: c = 8'h3F;
      7'd55: c = 8'h2A;
      7'd57: c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

[rtl/core/ps2kq_ram.sv]
module ps2kq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Single write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/ps2kq_front.sv]
module ps2kq_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  logic            full_i,
  input  ps2kq_pkg::in_t  in_data_i,
  output logic            cmd_push_o,
  output ps2kq_pkg::cmd_t cmd_o
);

  ps2kq_pkg::mods_t  mods_q, mods_d;
  ps2kq_pkg::event_t evt;
  logic              accept;
  logic              released;
  logic [6:0]        key;
  logic [7:0]        chr_sel;
  logic              is_mod;

  assign accept   = push_i && !full_i;
  assign key      = in_data_i.scan_byte[6:0];
  assign released = in_data_i.scan_byte[7];

  // Translate key to ASCII, shift xor caps picks the table
  always_comb begin
    if (mods_q.shift ^ mods_q.caps) chr_sel = ps2kq_pkg::shifted_char(key);
    else chr_sel = ps2kq_pkg::plain_char(key);
    evt.key_code   = key;
    evt.char_code  = chr_sel[6:0];
    if (key == ps2kq_pkg::SC_ENTER)     evt.char_code = ps2kq_pkg::CH_NEWLINE;
    if (key == ps2kq_pkg::SC_BACKSPACE) evt.char_code = ps2kq_pkg::CH_BACKSPACE;
    if (key == ps2kq_pkg::SC_TAB)       evt.char_code = ps2kq_pkg::CH_TAB;
    if (key == ps2kq_pkg::SC_SPACE)     evt.char_code = ps2kq_pkg::CH_SPACE;
    evt.is_press   = !released;
    evt.shift_down = mods_q.shift;
    evt.ctrl_down  = mods_q.ctrl;
    evt.alt_down   = mods_q.alt;
  end

  // Classify: modifier updates are absorbed, everything else becomes a command
  always_comb begin
    mods_d = mods_q;
    is_mod = 1'b1;
    if (key == ps2kq_pkg::SC_LSHIFT || key == ps2kq_pkg::SC_RSHIFT) begin
      mods_d.shift = !released;
    end else if (key == ps2kq_pkg::SC_LCTRL) begin
      mods_d.ctrl = !released;
    end else if (key == ps2kq_pkg::SC_LALT) begin
      mods_d.alt = !released;
    end else if (key == ps2kq_pkg::SC_CAPS && !released) begin
      mods_d.caps = !mods_q.caps;
    end else begin
      is_mod = 1'b0;
    end
    if (!accept || in_data_i.action == ps2kq_pkg::ACT_READ) begin
      mods_d = mods_q;
    end
  end

  assign cmd_push_o    = accept && (in_data_i.action == ps2kq_pkg::ACT_READ || !is_mod);
  assign cmd_o.is_read = (in_data_i.action == ps2kq_pkg::ACT_READ);
  assign cmd_o.evt     = evt;

  // Held modifier flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mods_q <= '0;
    end else begin
      mods_q <= mods_d;
    end
  end

endmodule

[rtl/core/ps2kq_cmdq.sv]
module ps2kq_cmdq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  ps2kq_pkg::cmd_t      cmd_i,
  output logic                 full_o,
  output ps2kq_pkg::cmd_head_t head_o,
  input  logic                 pop_i
);

  ps2kq_pkg::cmd_t                 slot_q [ps2kq_pkg::CMDQ_DEPTH];
  logic [ps2kq_pkg::CMDQ_PTR_W-1:0] wptr_q, wptr_d;
  logic [ps2kq_pkg::CMDQ_PTR_W-1:0] rptr_q, rptr_d;
  logic [ps2kq_pkg::CMDQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                             do_push, do_pop;

  function automatic logic [ps2kq_pkg::CMDQ_PTR_W-1:0] ptr_inc(
      input logic [ps2kq_pkg::CMDQ_PTR_W-1:0] p);
    logic [ps2kq_pkg::CMDQ_PTR_W-1:0] r;
    if (p == ps2kq_pkg::CMDQ_PTR_W'(ps2kq_pkg::CMDQ_DEPTH - 1)) r = '0;
    else r = p + 1'b1;
    return r;
  endfunction

  assign full_o       = (cnt_q == ps2kq_pkg::CMDQ_CNT_W'(ps2kq_pkg::CMDQ_DEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.cmd   = slot_q[rptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  // Pointer and count update
  always_comb begin
    wptr_d = do_push ? ptr_inc(wptr_q) : wptr_q;
    rptr_d = do_pop ? ptr_inc(rptr_q) : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    if (!do_push && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Slot storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= cmd_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ps2kq_pkg::CMDQ_CNT_W'(ps2kq_pkg::CMDQ_DEPTH))
    else $error("command queue count overflow");

endmodule

[rtl/core/ps2kq_back.sv]
module ps2kq_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ps2kq_pkg::cmd_head_t head_i,
  output logic                 head_pop_o,
  output logic                 empty_o,
  input  logic                 pop_i,
  output ps2kq_pkg::out_t      out_data_o
);

  logic [ps2kq_pkg::RING_PTR_W-1:0] wr_q, wr_d;
  logic [ps2kq_pkg::RING_PTR_W-1:0] rd_q, rd_d;
  logic [ps2kq_pkg::RING_PTR_W-1:0] wr_next;
  logic                             ring_full, ring_empty;
  logic                             ring_we;
  logic [ps2kq_pkg::EVENT_W-1:0]    ring_rdata;
  ps2kq_pkg::event_t                rd_evt;

  // Read in flight: RAM data arrives in the cycle after issue
  logic                             pend_q, pend_empty_q;
  logic                             issue_rd;
  logic                             credit_ok;

  // Result queue
  ps2kq_pkg::out_t                  res_q [ps2kq_pkg::OUT_DEPTH];
  ps2kq_pkg::out_t                  res_in;
  logic [ps2kq_pkg::OUT_PTR_W-1:0]  owptr_q, orptr_q;
  logic [ps2kq_pkg::OUT_CNT_W-1:0]  ocnt_q, ocnt_d;
  logic                             o_push, o_pop;

  function automatic logic [ps2kq_pkg::OUT_PTR_W-1:0] optr_inc(
      input logic [ps2kq_pkg::OUT_PTR_W-1:0] p);
    logic [ps2kq_pkg::OUT_PTR_W-1:0] r;
    if (p == ps2kq_pkg::OUT_PTR_W'(ps2kq_pkg::OUT_DEPTH - 1)) r = '0;
    else r = p + 1'b1;
    return r;
  endfunction

  // Ring status
  assign wr_next    = ps2kq_pkg::ring_next(wr_q);
  assign ring_full  = (wr_next == rd_q);
  assign ring_empty = (wr_q == rd_q);

  // A read needs a free slot in the result queue, counting the one in flight
  assign credit_ok = (ocnt_q + ps2kq_pkg::OUT_CNT_W'(pend_q))
                     < ps2kq_pkg::OUT_CNT_W'(ps2kq_pkg::OUT_DEPTH);

  // Execute the head command
  always_comb begin
    head_pop_o = 1'b0;
    issue_rd   = 1'b0;
    ring_we    = 1'b0;
    wr_d       = wr_q;
    rd_d       = rd_q;
    if (head_i.valid) begin
      if (head_i.cmd.is_read) begin
        if (credit_ok) begin
          head_pop_o = 1'b1;
          issue_rd   = 1'b1;
          if (!ring_empty) rd_d = ps2kq_pkg::ring_next(rd_q);
        end
      end else begin
        head_pop_o = 1'b1;
        if (!ring_full) begin
          ring_we = 1'b1;
          wr_d    = wr_next;
        end
      end
    end
  end

  ps2kq_ram #(
    .Width (ps2kq_pkg::EVENT_W),
    .Depth (ps2kq_pkg::RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (wr_q),
    .wdata_i (head_i.cmd.evt),
    .raddr_i (rd_q),
    .rdata_o (ring_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      pend_q <= 1'b0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      pend_q <= issue_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_empty_q <= ring_empty;
  end

  // Form the result from RAM data or the empty marker
  assign rd_evt = ps2kq_pkg::event_t'(ring_rdata);
  always_comb begin
    res_in = '0;
    if (pend_empty_q) begin
      res_in.queue_empty = 1'b1;
    end else begin
      res_in.key_code   = rd_evt.key_code;
      res_in.char_code  = rd_evt.char_code;
      res_in.is_press   = rd_evt.is_press;
      res_in.shift_down = rd_evt.shift_down;
      res_in.ctrl_down  = rd_evt.ctrl_down;
      res_in.alt_down   = rd_evt.alt_down;
    end
  end

  // Result queue control
  assign empty_o    = (ocnt_q == '0);
  assign out_data_o = res_q[orptr_q];
  assign o_push     = pend_q;
  assign o_pop      = pop_i && !empty_o;

  always_comb begin
    ocnt_d = ocnt_q;
    if (o_push && !o_pop) ocnt_d = ocnt_q + 1'b1;
    if (!o_push && o_pop) ocnt_d = ocnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owptr_q <= '0;
      orptr_q <= '0;
      ocnt_q  <= '0;
    end else begin
      if (o_push) owptr_q <= optr_inc(owptr_q);
      if (o_pop) orptr_q <= optr_inc(orptr_q);
      ocnt_q <= ocnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_push) begin
      res_q[owptr_q] <= res_in;
    end
  end

  // The in-flight read always finds room in the result queue
  a_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ocnt_q + ps2kq_pkg::OUT_CNT_W'(pend_q)) <= ps2kq_pkg::OUT_CNT_W'(ps2kq_pkg::OUT_DEPTH))
    else $error("result queue overcommitted");

  // A ring write never makes the ring look empty
  a_no_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_we |=> (wr_q != rd_q))
    else $error("ring overrun");

  // Each issued read yields exactly one result next cycle
  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_rd |=> o_push)
    else $error("issued read lost");

  // An empty-ring read leaves the read pointer in place
  a_empty_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue_rd && ring_empty) |=> $stable(rd_q))
    else $error("read pointer moved on empty ring");

endmodule

[rtl/core/ps2_scancode_key_event_queue_unit.sv]
// A read transaction's result passes the command queue, the registered event-ring RAM
//   read and the result queue before it shows on the result ports.
// Throughput: one transaction per cycle per side while full and empty are low; the ring RAM
//   takes one write or one read per cycle; a 4-entry result queue absorbs output stalls.
// Reset (rst_ni low, asynchronous): modifier flags, ring pointers and queue counts clear;
//   ring contents are left as they are, so no clearing pass is needed.
module ps2_scancode_key_event_queue_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  ps2kq_pkg::in_t  in_data_i,
  output logic            empty,
  input  logic            pop,
  output ps2kq_pkg::out_t out_data_o
);

  logic                 cmd_push;
  ps2kq_pkg::cmd_t      cmd;
  ps2kq_pkg::cmd_head_t head;
  logic                 head_pop;

  // Classify incoming bytes and track modifiers
  ps2kq_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_i     (full),
    .in_data_i  (in_data_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd)
  );

  // Decoupling queue
  ps2kq_cmdq u_cmdq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .cmd_i  (cmd),
    .full_o (full),
    .head_o (head),
    .pop_i  (head_pop)
  );

  // Event ring and result delivery
  ps2kq_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .head_pop_o (head_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_data_o (out_data_o)
  );

endmodule

[dv/ps2_scancode_key_event_queue_unit_test.sv]
`timescale 1ns / 100ps

module ps2_scancode_key_event_queue_unit_test;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned TARGET_ITEMS = 1100;
  localparam int unsigned CALM_TAIL    = 150;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned MAX_REPORTS  = 10;

  // Keyboard state and event ring as the block should see them
  class key_event_scoreboard;
    // US layout rows; blanks are keys with no character
    string plain_keys   = "  1234567890-=  qwertyuiop[]  asdfghjkl;'` \\zxcvbnm,./ * ";
    string shifted_keys = "  !@#$%^&*()_+  QWERTYUIOP{}  ASDFGHJKL:\"~ |ZXCVBNM<>? * ";

    bit                  shift_dn;
    bit                  ctrl_dn;
    bit                  alt_dn;
    bit                  caps_on;
    ps2kq_pkg::out_t     ring_mem [ps2kq_pkg::RING_DEPTH];
    int unsigned         wr_idx;
    int unsigned         rd_idx;
    ps2kq_pkg::out_t     expected_q [$];

    int unsigned mismatches;
    int unsigned events_read;
    int unsigned empty_reads;
    int unsigned events_dropped;

    function int unsigned next_idx(int unsigned p);
      return (p == ps2kq_pkg::RING_DEPTH - 1) ? 0 : p + 1;
    endfunction

    function logic [6:0] char_for(logic [6:0] key);
      logic [6:0] c;
      c = '0;
      if (key <= 7'd57) begin
        c = (shift_dn ^ caps_on) ? 7'(shifted_keys[key]) : 7'(plain_keys[key]);
      end
      case (key)
        ps2kq_pkg::SC_ENTER:     c = ps2kq_pkg::CH_NEWLINE;
        ps2kq_pkg::SC_BACKSPACE: c = ps2kq_pkg::CH_BACKSPACE;
        ps2kq_pkg::SC_TAB:       c = ps2kq_pkg::CH_TAB;
        ps2kq_pkg::SC_SPACE:     c = ps2kq_pkg::CH_SPACE;
        7'd0, 7'd1, 7'd29, 7'd42, 7'd54, 7'd56: c = '0;
        default: ;
      endcase
      return c;
    endfunction

    function string show(ps2kq_pkg::out_t r);
      return $sformatf("empty=%0b key=%02h char=%02h press=%0b shift=%0b ctrl=%0b alt=%0b",
                       r.queue_empty, r.key_code, r.char_code, r.is_press,
                       r.shift_down, r.ctrl_down, r.alt_down);
    endfunction

    function void note_error(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("ERROR: %s", msg);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Accepted input transaction: update state, queue a result for reads
    function void note_input(ps2kq_pkg::in_t item);
      logic [6:0]      key;
      logic            released;
      ps2kq_pkg::out_t ev;
      key      = item.scan_byte[6:0];
      released = item.scan_byte[7];
      ev       = '0;
      if (item.action == ps2kq_pkg::ACT_READ) begin
        if (wr_idx == rd_idx) begin
          ev.queue_empty = 1'b1;
          empty_reads++;
        end else begin
          ev     = ring_mem[rd_idx];
          rd_idx = next_idx(rd_idx);
        end
        expected_q.push_back(ev);
      end else if (key == ps2kq_pkg::SC_LSHIFT || key == ps2kq_pkg::SC_RSHIFT) begin
        shift_dn = !released;
      end else if (key == ps2kq_pkg::SC_LCTRL) begin
        ctrl_dn = !released;
      end else if (key == ps2kq_pkg::SC_LALT) begin
        alt_dn = !released;
      end else if (key == ps2kq_pkg::SC_CAPS && !released) begin
        caps_on = !caps_on;
      end else begin
        ev.key_code   = key;
        ev.char_code  = char_for(key);
        ev.is_press   = !released;
        ev.shift_down = shift_dn;
        ev.ctrl_down  = ctrl_dn;
        ev.alt_down   = alt_dn;
        // ring keeps one slot free
        if (next_idx(wr_idx) == rd_idx) begin
          events_dropped++;
        end else begin
          ring_mem[wr_idx] = ev;
          wr_idx = next_idx(wr_idx);
        end
      end
    endfunction

    // Accepted result transaction: compare with the oldest expectation
    function void check_result(ps2kq_pkg::out_t got);
      ps2kq_pkg::out_t want;
      if (expected_q.size() == 0) begin
        note_error($sformatf("result with nothing expected: %s", show(got)));
      end else begin
        want = expected_q.pop_front();
        if (got.queue_empty !== want.queue_empty || got.key_code !== want.key_code ||
            got.char_code !== want.char_code || got.is_press !== want.is_press ||
            got.shift_down !== want.shift_down || got.ctrl_down !== want.ctrl_down ||
            got.alt_down !== want.alt_down) begin
          note_error($sformatf("mismatch: expected %s, got %s", show(want), show(got)));
        end else if (!got.queue_empty) begin
          events_read++;
        end
      end
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni  = 1'b0;
  logic            push    = 1'b0;
  logic            pop     = 1'b0;
  ps2kq_pkg::in_t  in_data = '0;
  logic            full;
  logic            empty;
  ps2kq_pkg::out_t out_data;

  key_event_scoreboard sb;
  int unsigned items_sent;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned cycle_count;

  ps2_scancode_key_event_queue_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("ps2_scancode_key_event_queue_unit_test: errors");
      $finish;
    end
  end

  // Monitor both handshakes on pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) sb.note_input(in_data);
      if (pop && !empty) sb.check_result(out_data);
    end
  end

  // Result side: pop with random stall bursts
  initial begin
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (recv_stall_pct != 0 && $urandom_range(1, 100) <= recv_stall_pct) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end else begin
        pop <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // One input transaction, with an optional idle burst ahead of it
  task automatic push_item(logic act, logic [7:0] b);
    if (send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    push    <= 1'b1;
    in_data <= '{action: act, scan_byte: b};
    do @(posedge clk_i); while (full);
    items_sent++;
  endtask

  task automatic read_some(int unsigned n);
    repeat (n) push_item(ps2kq_pkg::ACT_READ, 8'($urandom));
  endtask

  // Any key that is not a modifier, mostly from the mapped range
  function automatic logic [6:0] pick_key();
    logic [6:0] k;
    do begin
      k = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(1, 58));
    end while (k == ps2kq_pkg::SC_LSHIFT || k == ps2kq_pkg::SC_RSHIFT ||
               k == ps2kq_pkg::SC_LCTRL || k == ps2kq_pkg::SC_LALT ||
               k == ps2kq_pkg::SC_CAPS);
    return k;
  endfunction

  // Press and release of one key, possibly under modifiers
  task automatic type_key();
    logic [6:0] key;
    logic [6:0] shift_key;
    bit         with_shift;
    bit         with_ctrl;
    bit         with_alt;
    key        = pick_key();
    shift_key  = $urandom_range(0, 1) ? ps2kq_pkg::SC_LSHIFT : ps2kq_pkg::SC_RSHIFT;
    with_shift = ($urandom_range(0, 2) == 0);
    with_ctrl  = ($urandom_range(0, 4) == 0);
    with_alt   = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 9) == 0) push_item(ps2kq_pkg::ACT_BYTE, {1'b0, ps2kq_pkg::SC_CAPS});
    if (with_shift) push_item(ps2kq_pkg::ACT_BYTE, {1'b0, shift_key});
    if (with_ctrl) push_item(ps2kq_pkg::ACT_BYTE, {1'b0, ps2kq_pkg::SC_LCTRL});
    if (with_alt) push_item(ps2kq_pkg::ACT_BYTE, {1'b0, ps2kq_pkg::SC_LALT});
    push_item(ps2kq_pkg::ACT_BYTE, {1'b0, key});
    read_some($urandom_range(0, 2));
    push_item(ps2kq_pkg::ACT_BYTE, {1'b1, key});
    read_some($urandom_range(1, 2));
    // modifiers are sometimes left held into the next keystroke
    if (with_shift && $urandom_range(0, 4) != 0) begin
      push_item(ps2kq_pkg::ACT_BYTE, {1'b1, shift_key});
    end
    if (with_ctrl && $urandom_range(0, 4) != 0) begin
      push_item(ps2kq_pkg::ACT_BYTE, {1'b1, ps2kq_pkg::SC_LCTRL});
    end
    if (with_alt && $urandom_range(0, 4) != 0) begin
      push_item(ps2kq_pkg::ACT_BYTE, {1'b1, ps2kq_pkg::SC_LALT});
    end
  endtask

  // Overrun the ring, then drain it past empty
  task automatic fill_ring();
    repeat (ps2kq_pkg::RING_DEPTH + 8) push_item(ps2kq_pkg::ACT_BYTE, {1'b0, pick_key()});
    read_some(ps2kq_pkg::RING_DEPTH + 4);
  endtask

  // Hold the input side until every read has been answered
  task automatic hold_until_drained();
    push <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Stimulus
  initial begin
    int unsigned pick;
    int unsigned fills;
    bit          paused;
    sb = new;
    fills  = 0;
    paused = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty read, byte extremes, every modifier, caps, forced keys, E0
    push_item(ps2kq_pkg::ACT_READ, 8'hFF);
    push_item(ps2kq_pkg::ACT_BYTE, 8'h00);
    push_item(ps2kq_pkg::ACT_BYTE, 8'hFF);
    push_item(ps2kq_pkg::ACT_BYTE, {1'b0, ps2kq_pkg::SC_LSHIFT});
    push_item(ps2kq_pkg::ACT_BYTE, 8'h1E);
    push_item(ps2kq_pkg::ACT_BYTE, {1'b1, ps2kq_pkg::SC_LSHIFT});
    push_item(ps2kq_pkg::ACT_BYTE, {1'b0, ps2kq_pkg::SC_RSHIFT});
    push_item(ps2kq_pkg::ACT_BYTE, 8'h35);
    push_item(ps2kq_pkg::ACT_BYTE, {1'b1, ps2kq_pkg::SC_RSHIFT});
    push_item(ps2kq_pkg::ACT_BYTE, {1'b0, ps2kq_pkg::SC_LCTRL});
    push_item(ps2kq_pkg::ACT_BYTE, {1'b0, ps2kq_pkg::SC_LALT});
    push_item(ps2kq_pkg::ACT_BYTE, 8'h02);
    push_item(ps2kq_pkg::ACT_BYTE, {1'b1, ps2kq_pkg::SC_LCTRL});
    push_item(ps2kq_pkg::ACT_BYTE, {1'b1, ps2kq_pkg::SC_LALT});
    push_item(ps2kq_pkg::ACT_BYTE, {1'b0, ps2kq_pkg::SC_CAPS});
    push_item(ps2kq_pkg::ACT_BYTE, 8'h02);
    push_item(ps2kq_pkg::ACT_BYTE, {1'b1, ps2kq_pkg::SC_CAPS});
    push_item(ps2kq_pkg::ACT_BYTE, {1'b0, ps2kq_pkg::SC_ENTER});
    push_item(ps2kq_pkg::ACT_BYTE, {1'b0, ps2kq_pkg::SC_BACKSPACE});
    push_item(ps2kq_pkg::ACT_BYTE, {1'b0, ps2kq_pkg::SC_TAB});
    push_item(ps2kq_pkg::ACT_BYTE, {1'b0, ps2kq_pkg::SC_SPACE});
    push_item(ps2kq_pkg::ACT_BYTE, 8'hE0);
    push_item(ps2kq_pkg::ACT_BYTE, {1'b0, ps2kq_pkg::SC_CAPS});
    read_some(16);

    // Random part
    fill_ring();
    while (items_sent < TARGET_ITEMS) begin
      if (items_sent > TARGET_ITEMS - CALM_TAIL) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end else if ($urandom_range(0, 3) == 0) begin
        send_idle_pct  = $urandom_range(0, 1) * 30;
        recv_stall_pct = $urandom_range(0, 1) * 30;
      end
      if (!paused && items_sent >= TARGET_ITEMS / 2) begin
        hold_until_drained();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        repeat ($urandom_range(1, 6)) type_key();
      end else if (pick < 8) begin
        repeat (12) push_item(1'($urandom_range(0, 1)), 8'($urandom));
      end else if (fills < 2) begin
        fill_ring();
        fills++;
      end else begin
        read_some(4);
      end
    end

    // Drain and settle
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.pending() != 0) sb.note_error($sformatf("%0d results never arrived", sb.pending()));

    $display("covered %0d input transactions: %0d key events read back, %0d empty reads,",
             items_sent, sb.events_read, sb.empty_reads);
    $display("%0d events dropped on a full ring, %0d mismatches", sb.events_dropped,
             sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("ps2_scancode_key_event_queue_unit_test: clean");
    end else begin
      $display("ps2_scancode_key_event_queue_unit_test: errors");
    end
    $finish;
  end

endmodule

[ps2_scancode_key_event_queue_unit.f]
rtl/core/ps2kq_pkg.sv
rtl/core/ps2kq_ram.sv
rtl/core/ps2kq_front.sv
rtl/core/ps2kq_cmdq.sv
rtl/core/ps2kq_back.sv
rtl/core/ps2_scancode_key_event_queue_unit.sv
dv/ps2_scancode_key_event_queue_unit_test.sv
